>>> design/grv_pkg.sv
// shared constants, types and the quarter-wave sine table of the grid raycast block
package grv_pkg;

    // grid and traversal sizes
    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 256;
    localparam int MAX_RAYS  = 512;
    localparam int FRAC_BITS = 8;

    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int MAP_DEPTH = GRID_COLS * GRID_ROWS;

    // item field widths
    localparam int RAD_W = 14;
    localparam int POS_W = 16;
    localparam logic [RAD_W-1:0] RAD_RESET = 14'd2048;

    // shared multiplier: operand a, operand b, product
    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TWO_PI_Q16 = 411775;
    localparam int NSHIFT = 16 + FRAC_BITS;

    // ray count, phase and step division
    localparam int N_W       = $clog2(MAX_RAYS + 1);
    localparam int PHASE_W   = 12;
    localparam int QUO_W     = PHASE_W + 1;
    localparam int QUARTER   = 1 << (PHASE_W - 2);
    localparam int DIVCNT_W  = $clog2(QUO_W);

    // trig and offsets
    localparam int TRIG_W  = 15;
    localparam logic [TRIG_W-1:0] TRIG_MAX = 15'd16384;
    localparam int DMAG_W  = 14;
    localparam int SUM_W   = POS_W + 2;
    localparam int TILE_W  = 11;
    localparam int STEP_W  = 10;
    localparam int NPOS_W  = 16;
    localparam int ONE_POS = 1 << FRAC_BITS;

    // action codes
    typedef enum logic [1:0] {
        ACT_WRITE    = 2'd0,
        ACT_DISCOVER = 2'd1,
        ACT_QUERY    = 2'd2,
        ACT_REVEAL   = 2'd3
    } t_action;

    // q1.14 quarter-wave sine, 64 steps per quarter turn
    function automatic logic [TRIG_W-1:0] sine_entry(input logic [6:0] k);
        logic [TRIG_W-1:0] v;
        unique case (k)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd402;   7'd2:  v = 15'd804;
            7'd3:  v = 15'd1205;  7'd4:  v = 15'd1606;  7'd5:  v = 15'd2006;
            7'd6:  v = 15'd2404;  7'd7:  v = 15'd2801;  7'd8:  v = 15'd3196;
            7'd9:  v = 15'd3590;  7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
            7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
            7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
            7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
            7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
            7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
            7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
            7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
            7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
            7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
            7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
            7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
            7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
            7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
            7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
            7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
            7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
            7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
            7'd63: v = 15'd16379;
            default: v = TRIG_MAX;
        endcase
        return v;
    endfunction

endpackage

>>> design/grv_item_if.sv
// input channel: valid/ready handshake with the action item payload
interface grv_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0] tile_col;
    logic [7:0] tile_row;
    logic       passable_bit;

    modport source (output valid, action, origin_x, origin_y, tile_col, tile_row,
                    passable_bit, input ready);
    modport sink   (input valid, action, origin_x, origin_y, tile_col, tile_row,
                    passable_bit, output ready);
endinterface

>>> design/grv_result_if.sv
// output channel: valid/ready handshake with the result item payload
interface grv_result_if;
    logic       valid;
    logic       ready;
    logic       is_seen;
    logic [1:0] done_action;

    modport source (output valid, is_seen, done_action, input ready);
    modport sink   (input valid, is_seen, done_action, output ready);
endinterface

>>> design/grv_ram.sv
// generic simple dual-port ram with registered read
module grv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/grid_raycast_visibility.sv
// top level of the grid raycast visibility unit
// Keeps a passable map and a seen map over the tile grid, both one-bit rams. After reset
// a clearing pass writes the seen map to zero, one tile a cycle, and no item is accepted
// meanwhile. One item is worked at a time; a reveal is the same one-tile-a-cycle sweep.
// A discover first sets up the ray count (multiply) and the step (a 13-step divide), then
// per ray works out sine/cosine and scaling on the one shared multiplier, then walks the
// tiles, each with a seen write and passable read in one state and a step decision on the
// multiplier in the next; at the largest radius roughly 403 rays times up to about
// 92 tiles. The next item is taken while the last result still waits at the output
// register.
module grid_raycast_visibility (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    grv_item_if.sink                   i_item,
    grv_result_if.source               o_result,
    input  logic                       i_cfg_wr_en,
    input  logic [grv_pkg::RAD_W-1:0]  i_cfg_wr_data
);
    import grv_pkg::*;

    typedef enum logic [3:0] {
        S_FILL, S_IDLE, S_QRD, S_QCAP, S_NMUL, S_NSET, S_DIV, S_INTERP,
        S_MAG, S_SCALE, S_OFF, S_SETUP, S_MARK, S_STEP, S_NEXT, S_DONE
    } t_state;

    localparam logic [QUO_W-1:0] DIVIDEND = QUO_W'(1 << PHASE_W);

    t_state               r_state;
    logic [RAD_W-1:0]     r_radius;
    logic [ADDR_W-1:0]    r_sweep;
    logic                 r_fill;
    t_action              r_action;
    logic [POS_W-1:0]     r_ox, r_oy;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic                 r_qbit;
    logic                 r_out_valid, r_out_seen;
    logic [1:0]           r_out_action;
    logic [PROD_W-1:0]    r_prod;
    logic [N_W-1:0]       r_n, r_div_rem, r_step_r, r_ray, r_prem;
    logic [DIVCNT_W-1:0]  r_div_cnt;
    logic [QUO_W-1:0]     r_step_q;
    logic [PHASE_W-1:0]   r_phase;
    logic                 r_axis, r_sat, r_neg;
    logic [TRIG_W-1:0]    r_lo, r_mag;
    logic [DMAG_W-1:0]    r_dx_mag, r_dy_mag;
    logic                 r_dx_neg, r_dy_neg;
    logic signed [TILE_W-1:0] r_x, r_y;
    logic                 r_sx_zero, r_sy_zero;
    logic [NPOS_W-1:0]    r_nx, r_ny;
    logic [STEP_W-1:0]    r_steps;

    logic                 accept;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic                 seen_we, seen_wdata, seen_rdata, pass_we, pass_rdata;
    logic [ADDR_W-1:0]    seen_waddr, tile_addr;

    // handshake and result register
    assign i_item.ready         = (r_state == S_IDLE);
    assign accept               = i_item.valid && (r_state == S_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.is_seen     = r_out_seen;
    assign o_result.done_action = r_out_action;

    // sine/cosine table lookup for the current axis
    logic [PHASE_W-1:0] ph;
    logic [1:0]         quad;
    logic [10:0]        wq;
    logic [6:0]         tk;
    logic [3:0]         tf;
    logic [TRIG_W-1:0]  t_lo, t_hi, t_diff;
    always_comb begin
        ph     = r_axis ? r_phase : r_phase + PHASE_W'(QUARTER);
        quad   = ph[PHASE_W-1 -: 2];
        wq     = quad[0] ? 11'(QUARTER) - {1'b0, ph[PHASE_W-3:0]} : {1'b0, ph[PHASE_W-3:0]};
        tk     = wq[10:4];
        tf     = wq[3:0];
        t_lo   = sine_entry(tk);
        t_hi   = sine_entry(tk + 7'd1);
        t_diff = t_hi - t_lo;
    end

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_NMUL: begin
                mul_a = MUL_A_W'(TWO_PI_Q16);
                mul_b = MUL_B_W'(r_radius);
            end
            S_INTERP: begin
                mul_a = MUL_A_W'(t_diff);
                mul_b = MUL_B_W'(tf);
            end
            S_SCALE: begin
                mul_a = MUL_A_W'(r_radius);
                mul_b = MUL_B_W'(r_mag);
            end
            S_MARK: begin
                mul_a = MUL_A_W'(r_dy_mag);
                mul_b = r_nx;
            end
            S_STEP: begin
                mul_a = MUL_A_W'(r_dx_mag);
                mul_b = r_ny;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // ray count and step divide
    logic [N_W-1:0] n_base, n_cnt;
    logic [N_W:0]   div_shift;
    logic           div_ge;
    logic [N_W-1:0] div_next;
    always_comb begin
        n_base    = N_W'(r_prod >> NSHIFT);
        n_cnt     = (n_base >= N_W'(MAX_RAYS)) ? N_W'(MAX_RAYS) : n_base + N_W'(1);
        div_shift = {r_div_rem, DIVIDEND[r_div_cnt]};
        div_ge    = div_shift >= {1'b0, r_n};
        div_next  = div_ge ? N_W'(div_shift - {1'b0, r_n}) : N_W'(div_shift);
    end

    // next ray phase, floor(i * 4096 / n) kept as quotient and remainder
    logic [QUO_W:0]     phase_sum;
    logic [N_W:0]       rem_sum;
    logic               rem_ge;
    always_comb begin
        rem_sum   = {1'b0, r_prem} + {1'b0, r_step_r};
        rem_ge    = rem_sum >= {1'b0, r_n};
        phase_sum = (QUO_W+1)'(r_phase) + (QUO_W+1)'(r_step_q) + (QUO_W+1)'(rem_ge);
    end

    // ray setup: end tiles, step counts and first crossing distances
    logic signed [SUM_W-1:0]  dx_s, dy_s, sum_x, sum_y;
    logic signed [TILE_W-1:0] ex, ey, x0, y0, dcol, drow, acol, arow;
    logic [STEP_W-1:0]        steps0;
    logic [FRAC_BITS-1:0]     fx, fy;
    always_comb begin
        dx_s   = r_dx_neg ? -SUM_W'(r_dx_mag) : SUM_W'(r_dx_mag);
        dy_s   = r_dy_neg ? -SUM_W'(r_dy_mag) : SUM_W'(r_dy_mag);
        sum_x  = signed'(SUM_W'(r_ox)) + dx_s;
        sum_y  = signed'(SUM_W'(r_oy)) + dy_s;
        ex     = TILE_W'(sum_x >>> FRAC_BITS);
        ey     = TILE_W'(sum_y >>> FRAC_BITS);
        x0     = signed'(TILE_W'(r_ox[POS_W-1:FRAC_BITS]));
        y0     = signed'(TILE_W'(r_oy[POS_W-1:FRAC_BITS]));
        dcol   = ex - x0;
        drow   = ey - y0;
        acol   = dcol[TILE_W-1] ? -dcol : dcol;
        arow   = drow[TILE_W-1] ? -drow : drow;
        steps0 = STEP_W'(acol) + STEP_W'(arow);
        fx     = r_ox[FRAC_BITS-1:0];
        fy     = r_oy[FRAC_BITS-1:0];
    end

    // tile walk: grid bounds and step choice
    logic x_out, y_out, mark_go, take_x;
    always_comb begin
        x_out     = r_x[TILE_W-1] || (r_x >= signed'(TILE_W'(GRID_COLS)));
        y_out     = r_y[TILE_W-1] || (r_y >= signed'(TILE_W'(GRID_ROWS)));
        mark_go   = (r_state == S_MARK) && (r_steps != '0) && !x_out && !y_out;
        tile_addr = {r_y[ROW_W-1:0], r_x[COL_W-1:0]};
        take_x    = !r_sx_zero && (r_sy_zero || (r_prod < mul_p));
    end

    // seen map write select: clearing/reveal sweep or ray marks
    always_comb begin
        seen_we    = 1'b0;
        seen_waddr = tile_addr;
        seen_wdata = 1'b1;
        if (r_state == S_FILL) begin
            seen_we    = 1'b1;
            seen_waddr = r_sweep;
            seen_wdata = r_fill;
        end else if (mark_go) begin
            seen_we    = 1'b1;
        end
    end

    assign pass_we = accept && (i_item.action == ACT_WRITE);

    grv_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (seen_we),
        .i_waddr (seen_waddr),
        .i_wdata (seen_wdata),
        .i_raddr ({r_row, r_col}),
        .o_rdata (seen_rdata)
    );

    grv_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_pass_ram (
        .i_clk   (i_clk),
        .i_we    (pass_we),
        .i_waddr ({i_item.tile_row, i_item.tile_col}),
        .i_wdata (i_item.passable_bit),
        .i_raddr (tile_addr),
        .o_rdata (pass_rdata)
    );

    // sequencer, configuration register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_sweep     <= '0;
            r_fill      <= 1'b0;
            r_out_valid <= 1'b0;
            r_radius    <= RAD_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_radius <= i_cfg_wr_data;
            end
            // result taken; the done state loads the register itself
            if (r_out_valid && o_result.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_FILL: begin
                    r_sweep <= r_sweep + ADDR_W'(1);
                    if (r_sweep == ADDR_W'(MAP_DEPTH - 1)) begin
                        r_state <= r_fill ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_action <= t_action'(i_item.action);
                        r_ox     <= i_item.origin_x;
                        r_oy     <= i_item.origin_y;
                        r_col    <= i_item.tile_col;
                        r_row    <= i_item.tile_row;
                        r_qbit   <= 1'b0;
                        unique case (t_action'(i_item.action))
                            ACT_WRITE:    r_state <= S_DONE;
                            ACT_DISCOVER: r_state <= S_NMUL;
                            ACT_QUERY:    r_state <= S_QRD;
                            ACT_REVEAL: begin
                                r_fill  <= 1'b1;
                                r_sweep <= '0;
                                r_state <= S_FILL;
                            end
                        endcase
                    end
                end
                S_QRD: r_state <= S_QCAP;
                S_QCAP: begin
                    r_qbit  <= seen_rdata;
                    r_state <= S_DONE;
                end
                S_NMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_NSET;
                end
                S_NSET: begin
                    r_n       <= n_cnt;
                    r_div_cnt <= DIVCNT_W'(QUO_W - 1);
                    r_div_rem <= '0;
                    r_step_q  <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_div_rem <= div_next;
                    r_step_q  <= {r_step_q[QUO_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt - DIVCNT_W'(1);
                    if (r_div_cnt == '0) begin
                        r_step_r <= div_next;
                        r_ray    <= '0;
                        r_phase  <= '0;
                        r_prem   <= '0;
                        r_axis   <= 1'b0;
                        r_state  <= S_INTERP;
                    end
                end
                S_INTERP: begin
                    r_prod  <= mul_p;
                    r_lo    <= t_lo;
                    r_sat   <= wq[10];
                    r_neg   <= quad[1];
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_mag   <= r_sat ? TRIG_MAX : r_lo + TRIG_W'((r_prod + PROD_W'(8)) >> 4);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod  <= mul_p;
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    if (!r_axis) begin
                        r_dx_mag <= DMAG_W'((r_prod + PROD_W'(8192)) >> 14);
                        r_dx_neg <= r_neg;
                        r_axis   <= 1'b1;
                        r_state  <= S_INTERP;
                    end else begin
                        r_dy_mag <= DMAG_W'((r_prod + PROD_W'(8192)) >> 14);
                        r_dy_neg <= r_neg;
                        r_state  <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_x       <= x0;
                    r_y       <= y0;
                    r_steps   <= steps0;
                    r_sx_zero <= (r_dx_mag == '0);
                    r_sy_zero <= (r_dy_mag == '0);
                    r_nx      <= r_dx_neg ? NPOS_W'(fx) : NPOS_W'(ONE_POS) - NPOS_W'(fx);
                    r_ny      <= r_dy_neg ? NPOS_W'(fy) : NPOS_W'(ONE_POS) - NPOS_W'(fy);
                    r_state   <= S_MARK;
                end
                S_MARK: begin
                    r_prod  <= mul_p;
                    r_state <= mark_go ? S_STEP : S_NEXT;
                end
                S_STEP: begin
                    if (!pass_rdata) begin
                        r_state <= S_NEXT;
                    end else begin
                        if (take_x) begin
                            r_nx <= r_nx + NPOS_W'(ONE_POS);
                            r_x  <= r_dx_neg ? r_x - TILE_W'(1) : r_x + TILE_W'(1);
                        end else begin
                            r_ny <= r_ny + NPOS_W'(ONE_POS);
                            r_y  <= r_dy_neg ? r_y - TILE_W'(1) : r_y + TILE_W'(1);
                        end
                        r_steps <= r_steps - STEP_W'(1);
                        r_state <= S_MARK;
                    end
                end
                S_NEXT: begin
                    if (r_ray == r_n - N_W'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_phase <= PHASE_W'(phase_sum);
                        r_prem  <= rem_ge ? N_W'(rem_sum - {1'b0, r_n}) : N_W'(rem_sum);
                        r_ray   <= r_ray + N_W'(1);
                        r_axis  <= 1'b0;
                        r_state <= S_INTERP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_seen   <= (r_action == ACT_QUERY) ? r_qbit : 1'b0;
                        r_out_action <= r_action;
                        r_fill       <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // a tile step only happens with steps left on the ray
    a_step_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> r_steps != '0)
        else $error("tile step with no steps left");

    // ray index and phase remainder stay below the ray count
    a_ray_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INTERP |-> (r_ray < r_n) && (r_prem < r_n))
        else $error("ray index or phase remainder out of range");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted item did not start");

endmodule

>>> verif/testbench.sv
// self-checking testbench of the grid raycast visibility unit with its own map predictor
`timescale 1ns / 100ps

module testbench;
    import grv_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_action     action;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  tile_col;
        logic [7:0]  tile_row;
        logic        passable_bit;
    } t_tile_req;

    typedef struct packed {
        logic    is_seen;
        t_action done_action;
    } t_tile_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [RAD_W-1:0] cfg_wr_data = '0;

    grv_item_if   item_ch ();
    grv_result_if resp_ch ();

    grid_raycast_visibility i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch.sink),
        .o_result     (resp_ch.source),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    bit        passable_tiles [MAP_DEPTH];
    bit        seen_tiles [MAP_DEPTH];
    int        ray_radius = 2048;
    const int  sine_quarter [65] = '{
        0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590, 3981, 4370, 4756,
        5139, 5520, 5897, 6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765, 9102,
        9434, 9760, 10080, 10394, 10702, 11003, 11297, 11585, 11866, 12140,
        12406, 12665, 12916, 13160, 13395, 13623, 13842, 14053, 14256, 14449,
        14635, 14811, 14978, 15137, 15286, 15426, 15557, 15679, 15791, 15893,
        15986, 16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384
    };

    t_tile_req  pending_reqs [$];
    t_tile_resp expected_resps [$];
    int  errors = 0;
    int  accepted_cnt = 0;
    int  checked_cnt = 0;
    int  discover_cnt = 0;
    int  seen_hits = 0;
    int  idle_mode = 2;
    int  hold_start = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  cycle_cnt = 0;

    // q2.14 sine of a phase in 4096ths of a turn
    function automatic int sine_of(int p);
        int quad, w, k, f, mag;
        quad = (p >> 10) & 3;
        w = p & 1023;
        if (quad & 1) begin
            w = 1024 - w;
        end
        k = w >> 4;
        f = w & 15;
        if (k >= 64) begin
            mag = sine_quarter[64];
        end else begin
            mag = sine_quarter[k] + (((sine_quarter[k+1] - sine_quarter[k]) * f + 8) >> 4);
        end
        return (quad & 2) ? -mag : mag;
    endfunction

    function automatic int ray_offset(int r, int trig);
        longint mag, d;
        mag = (trig < 0) ? -trig : trig;
        d = (longint'(r) * mag + 8192) >>> 14;
        return (trig < 0) ? -int'(d) : int'(d);
    endfunction

    function automatic int tile_floor(int v);
        if (v >= 0) begin
            return v >>> FRAC_BITS;
        end
        return -(((-v) + ONE_POS - 1) >>> FRAC_BITS);
    endfunction

    // walk one ray and mark tiles seen
    function automatic void walk_ray(int ox, int oy, int dx, int dy);
        int x, y, ex, ey, sx, sy, steps;
        longint adx, ady, nx, ny;
        bit take_x;
        x = ox >>> FRAC_BITS;
        y = oy >>> FRAC_BITS;
        ex = tile_floor(ox + dx);
        ey = tile_floor(oy + dy);
        sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        nx = (sx > 0) ? ONE_POS - (ox & (ONE_POS - 1)) : (ox & (ONE_POS - 1));
        ny = (sy > 0) ? ONE_POS - (oy & (ONE_POS - 1)) : (oy & (ONE_POS - 1));
        steps = ((ex > x) ? ex - x : x - ex) + ((ey > y) ? ey - y : y - ey);
        for (int s = 0; s < steps; s++) begin
            if (x < 0 || x >= GRID_COLS || y < 0 || y >= GRID_ROWS) begin
                break;
            end
            seen_tiles[y * GRID_COLS + x] = 1'b1;
            if (!passable_tiles[y * GRID_COLS + x]) begin
                break;
            end
            take_x = (sx != 0) && (sy == 0 || nx * ady < ny * adx);
            if (take_x) begin
                nx += ONE_POS;
                x += sx;
            end else begin
                ny += ONE_POS;
                y += sy;
            end
        end
    endfunction

    // apply one item to the predicted maps and return its result
    function automatic t_tile_resp predict_tile_item(t_tile_req q);
        t_tile_resp res;
        int idx, n, p;
        idx = int'(q.tile_row) * GRID_COLS + int'(q.tile_col);
        res.is_seen = 1'b0;
        res.done_action = q.action;
        case (q.action)
            ACT_WRITE: begin
                passable_tiles[idx] = q.passable_bit;
            end
            ACT_DISCOVER: begin
                n = int'((longint'(ray_radius) * TWO_PI_Q16) >>> NSHIFT) + 1;
                if (n > MAX_RAYS) begin
                    n = MAX_RAYS;
                end
                for (int i = 0; i < n; i++) begin
                    p = (i * 4096) / n;
                    walk_ray(q.origin_x, q.origin_y,
                             ray_offset(ray_radius, sine_of((p + 1024) & 4095)),
                             ray_offset(ray_radius, sine_of(p & 4095)));
                end
            end
            ACT_QUERY: begin
                res.is_seen = seen_tiles[idx];
            end
            default: begin
                foreach (seen_tiles[i]) seen_tiles[i] = 1'b1;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch on %s at result %0d: got %0d, want %0d", what, checked_cnt, got, want);
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    // item driver
    always @(posedge i_clk) begin
        t_tile_req q;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            item_ch.action <= ACT_WRITE;
            item_ch.origin_x <= '0;
            item_ch.origin_y <= '0;
            item_ch.tile_col <= '0;
            item_ch.tile_row <= '0;
            item_ch.passable_bit <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                q.action = t_action'(item_ch.action);
                q.origin_x = item_ch.origin_x;
                q.origin_y = item_ch.origin_y;
                q.tile_col = item_ch.tile_col;
                q.tile_row = item_ch.tile_row;
                q.passable_bit = item_ch.passable_bit;
                expected_resps.push_back(predict_tile_item(q));
                accepted_cnt++;
                if (q.action == ACT_DISCOVER) begin
                    discover_cnt++;
                end
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pending_reqs.size() > 0 &&
                    !(idle_mode == 0 && $urandom_range(0, 99) < 25) &&
                    !(idle_mode == 1 && $urandom_range(0, 99) < 53)) begin
                    q = pending_reqs.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.action <= q.action;
                    item_ch.origin_x <= q.origin_x;
                    item_ch.origin_y <= q.origin_y;
                    item_ch.tile_col <= q.tile_col;
                    item_ch.tile_row <= q.tile_row;
                    item_ch.passable_bit <= q.passable_bit;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_tile_resp want;
        if (!i_rst_n) begin
            resp_ch.ready <= 1'b0;
        end else begin
            if (resp_ch.valid && resp_ch.ready) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = expected_resps.pop_front();
                    if (resp_ch.done_action !== want.done_action) begin
                        report_mismatch("done_action", resp_ch.done_action, want.done_action);
                    end
                    if (resp_ch.is_seen !== want.is_seen) begin
                        report_mismatch("is_seen", resp_ch.is_seen, want.is_seen);
                    end
                    if (want.is_seen) begin
                        seen_hits++;
                    end
                end
                checked_cnt++;
            end
            if (hold_start != hold_seen) begin
                hold_seen <= hold_start;
                hold_left <= HOLD_CYCLES;
                resp_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                resp_ch.ready <= 1'b0;
            end else begin
                case (idle_mode)
                    0: resp_ch.ready <= ($urandom_range(0, 99) >= 53);
                    1: resp_ch.ready <= ($urandom_range(0, 99) >= 25);
                    default: resp_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic queue_item(t_action act, int ox, int oy, int col, int row, bit pbit);
        t_tile_req q;
        q.action = act;
        q.origin_x = ox[15:0];
        q.origin_y = oy[15:0];
        q.tile_col = col[7:0];
        q.tile_row = row[7:0];
        q.passable_bit = pbit;
        pending_reqs.push_back(q);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() > 0 || item_ch.valid || expected_resps.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_radius(int r);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r[RAD_W-1:0];
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        ray_radius = r;
        @(posedge i_clk);
    endtask

    // random item, queries aimed around the last viewer position
    task automatic queue_random(ref int cx, ref int cy);
        int pick, span;
        pick = $urandom_range(0, 99);
        span = (ray_radius >> FRAC_BITS) + 2;
        if (pick < 25) begin
            queue_item(ACT_WRITE, $urandom, $urandom, $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 99) < 85);
        end else if (pick < 45) begin
            cx = $urandom_range(0, 65535);
            cy = $urandom_range(0, 65535);
            queue_item(ACT_DISCOVER, cx, cy, $urandom, $urandom, $urandom);
        end else begin
            queue_item(ACT_QUERY, $urandom, $urandom,
                       ((cx >> FRAC_BITS) + $urandom_range(0, 2 * span) - span) & 255,
                       ((cy >> FRAC_BITS) + $urandom_range(0, 2 * span) - span) & 255,
                       $urandom);
        end
    endtask

    // stimulus
    initial begin
        int cx, cy;
        cx = 128 << FRAC_BITS;
        cy = 128 << FRAC_BITS;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // give every tile a passable bit, mostly open
        idle_mode = 2;
        for (int t = 0; t < MAP_DEPTH; t++) begin
            queue_item(ACT_WRITE, 0, 0, t % GRID_COLS, t / GRID_COLS,
                       $urandom_range(0, 99) < 88);
        end
        wait_drained();

        // directed: extremes, grid edges, exact tile corners
        idle_mode = 0;
        queue_item(ACT_WRITE, 16'hFFFF, 16'hFFFF, 255, 255, 1'b1);
        queue_item(ACT_WRITE, 0, 0, 0, 0, 1'b0);
        queue_item(ACT_DISCOVER, 16'h8080, 16'h8080, 0, 0, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 128, 128, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 130, 128, 1'b0);
        queue_item(ACT_DISCOVER, 0, 0, 0, 0, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 0, 0, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 1, 0, 1'b0);
        queue_item(ACT_DISCOVER, 16'hFFFF, 16'hFFFF, 255, 255, 1'b1);
        queue_item(ACT_QUERY, 0, 0, 255, 255, 1'b1);
        queue_item(ACT_QUERY, 0, 0, 250, 254, 1'b1);
        queue_item(ACT_DISCOVER, 16'h4000, 16'h2000, 0, 0, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 66, 32, 1'b0);
        wait_drained();
        set_radius(0);
        queue_item(ACT_DISCOVER, 16'h3080, 16'h3080, 0, 0, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 48, 48, 1'b0);
        wait_drained();
        set_radius(16383);
        queue_item(ACT_DISCOVER, 16'h7F00, 16'h80FF, 0, 0, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 127, 100, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 20, 200, 1'b0);
        wait_drained();
        set_radius(256);
        queue_item(ACT_DISCOVER, 16'h1000, 16'h1000, 0, 0, 1'b0);
        queue_item(ACT_QUERY, 0, 0, 17, 16, 1'b0);
        wait_drained();

        // random, sender idles less than the receiver
        set_radius($urandom_range(200, 1200));
        for (int i = 0; i < 35; i++) queue_random(cx, cy);
        wait_drained();

        // random the other way round, with a long receiver hold-off
        idle_mode = 1;
        set_radius($urandom_range(100, 2048));
        for (int i = 0; i < 10; i++) begin
            queue_item(ACT_QUERY, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
        end
        hold_start = 1;
        for (int i = 0; i < 30; i++) queue_random(cx, cy);
        wait_drained();

        // random with no idling
        idle_mode = 2;
        set_radius($urandom_range(300, 900));
        for (int i = 0; i < 30; i++) queue_random(cx, cy);
        wait_drained();

        // reveal last, since the seen map never clears again
        queue_item(ACT_REVEAL, $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_item(ACT_QUERY, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
        queue_item(ACT_QUERY, 0, 0, 0, 255, 1'b0);
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("%0d items accepted, %0d results checked, %0d discovers, %0d seen queries",
                 accepted_cnt, checked_cnt, discover_cnt, seen_hits);
        $display("radii from zero to the maximum, three idling patterns, one long hold-off");
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
